// File: rtl/swm_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window maximum: shared definitions
// Default sizes and the configuration register layout of the filter.
// ----------------------------------------------------------------------------
package swm_pkg;

   // Default depth of the window chain and default sample width.
   localparam int WINDOW_MAX  = 16;
   localparam int SAMPLE_BITS = 16;

   // Window length register.
   localparam int              CSR_W     = 5;
   localparam logic [CSR_W-1:0] LEN_RESET = 5'd3;

endpackage

// File: rtl/swm_ifs.sv
// ----------------------------------------------------------------------------
// Sliding window maximum: channel interfaces
// Valid/ready channels for samples, results and the window length register.
// ----------------------------------------------------------------------------
interface swm_req_if #(
   parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          end_of_stream;

   modport source (output valid, output sample, output end_of_stream, input ready);
   modport sink   (input valid, input sample, input end_of_stream, output ready);
endinterface

interface swm_rsp_if #(
   parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] window_max;
   logic                          last_window;

   modport source (output valid, output window_max, output last_window, input ready);
   modport sink   (input valid, input window_max, input last_window, output ready);
endinterface

interface swm_csr_if;
   logic                       valid;
   logic                       ready;
   logic [swm_pkg::CSR_W-1:0]  data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/swm_cell.sv
// ----------------------------------------------------------------------------
// Sliding window maximum: chain cell
// Holds one sample of the window and folds it into a passing running maximum.
// ----------------------------------------------------------------------------
module swm_cell #(
   parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          shift_en,
   input  logic signed [SAMPLE_BITS-1:0] prev_sample,
   input  logic                          tok_prev_valid,
   input  logic signed [SAMPLE_BITS-1:0] tok_prev_max,
   output logic signed [SAMPLE_BITS-1:0] cell_sample,
   output logic                          tok_valid,
   output logic signed [SAMPLE_BITS-1:0] tok_max
);

   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic                          tok_valid_ff;
   logic signed [SAMPLE_BITS-1:0] tok_max_ff, tok_max_in;

   assign sample_in  = shift_en ? prev_sample : sample_ff;
   assign tok_max_in = (tok_prev_max > sample_ff) ? tok_prev_max : sample_ff;

   always_ff @(posedge clock) begin
      sample_ff  <= sample_in;
      tok_max_ff <= tok_max_in;
   end

   // A shift moves the samples under any running maximum still in the row, so
   // such a maximum is stale and is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_valid_ff <= 1'b0;
      end else begin
         tok_valid_ff <= tok_prev_valid && !shift_en;
      end
   end

   assign cell_sample = sample_ff;
   assign tok_valid   = tok_valid_ff;
   assign tok_max     = tok_max_ff;

endmodule

// File: rtl/sliding_window_maximum_unit.sv
// ----------------------------------------------------------------------------
// Sliding window maximum unit
// Running maximum over the most recent window_len samples of a stream.
// ----------------------------------------------------------------------------
// Samples shift into a row of WINDOW_MAX cells, newest first. A sample that
// completes a full window starts a running maximum that walks down the row,
// one cell per cycle, and is taken at cell window_len-1. The input is ready
// again in the cycle its result is presented, so a result-producing sample
// occupies the block until then, while a sample without a result (stream not
// yet filled) leaves the input ready for the next one. A pending result waits
// in the output register and, if needed, one hold register. window_len is
// clamped to 1..WINDOW_MAX; end_of_stream marks the last sample, whose result
// carries last_window.
module sliding_window_maximum_unit #(
   parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX,
   parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS
) (
   input logic        clock,
   input logic        reset,
   swm_req_if.sink    req_ch,
   swm_rsp_if.source  rsp_ch,
   swm_csr_if.sink    csr_ch
);

   localparam int CNT_W = $clog2(WINDOW_MAX + 1);
   localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int LW    = (CNT_W > swm_pkg::CSR_W) ? CNT_W : swm_pkg::CSR_W;
   localparam logic [LW-1:0]    LEN_MAX  = LW'(WINDOW_MAX);
   localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(WINDOW_MAX);
   localparam logic signed [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   state_type                     state_ff, state_in;
   logic [swm_pkg::CSR_W-1:0]     window_len_ff, window_len_in;
   logic [CNT_W-1:0]              fill_ff, fill_in, fill_sat;
   logic [IDX_W-1:0]              tap_ff, tap_in;
   logic                          last_ff, last_in;
   logic                          launch_ff, launch_in;
   logic signed [SAMPLE_BITS-1:0] hold_max_ff, hold_max_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_max_ff, rsp_max_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic [LW-1:0]                 len_raw, len_lim;
   logic [CNT_W-1:0]              len_eff;
   logic                          req_xfer, produce, rsp_free, tap_hit;
   logic signed [SAMPLE_BITS-1:0] tap_max;

   logic signed [SAMPLE_BITS-1:0] sample_chain [WINDOW_MAX+1];
   logic                          tv_chain     [WINDOW_MAX+1];
   logic signed [SAMPLE_BITS-1:0] tm_chain     [WINDOW_MAX+1];
   logic [WINDOW_MAX-1:0]         tv_out;
   logic signed [SAMPLE_BITS-1:0] tm_out       [WINDOW_MAX];

   // ------------------------------------------------------------------ cells
   assign sample_chain[0] = req_ch.sample;
   assign tv_chain[0]     = launch_ff;
   assign tm_chain[0]     = MOST_NEG;

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      swm_cell #(
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .shift_en       (req_xfer),
         .prev_sample    (sample_chain[i]),
         .tok_prev_valid (tv_chain[i]),
         .tok_prev_max   (tm_chain[i]),
         .cell_sample    (sample_chain[i+1]),
         .tok_valid      (tv_chain[i+1]),
         .tok_max        (tm_chain[i+1])
      );
      assign tv_out[i] = tv_chain[i+1];
      assign tm_out[i] = tm_chain[i+1];
   end

   assign tap_hit = tv_out[tap_ff];
   assign tap_max = tm_out[tap_ff];

   // ---------------------------------------------------------- window length
   always_comb begin
      len_raw = LW'(window_len_ff);
      if (len_raw == '0) begin
         len_lim = LW'(1);
      end else if (len_raw > LEN_MAX) begin
         len_lim = LEN_MAX;
      end else begin
         len_lim = len_raw;
      end
      len_eff = CNT_W'(len_lim);
   end

   assign csr_ch.ready  = 1'b1;
   assign window_len_in = csr_ch.valid ? csr_ch.data : window_len_ff;

   // ---------------------------------------------------------------- control
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign fill_sat     = (fill_ff == FILL_MAX) ? fill_ff : fill_ff + CNT_W'(1);
   assign produce      = (fill_sat >= len_eff);
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      tap_in       = tap_ff;
      last_in      = last_ff;
      launch_in    = 1'b0;
      hold_max_in  = hold_max_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_max_in   = rsp_max_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               fill_in = req_ch.end_of_stream ? '0 : fill_sat;
               tap_in  = IDX_W'(len_eff - CNT_W'(1));
               last_in = req_ch.end_of_stream;
               if (produce) begin
                  launch_in = 1'b1;
                  state_in  = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (tap_hit) begin
               if (rsp_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_max_in   = tap_max;
                  rsp_last_in  = last_ff;
                  state_in     = ST_IDLE;
               end else begin
                  hold_max_in = tap_max;
                  state_in    = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_max_in   = hold_max_ff;
               rsp_last_in  = last_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         window_len_ff <= swm_pkg::LEN_RESET;
         fill_ff       <= '0;
         launch_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         window_len_ff <= window_len_in;
         fill_ff       <= fill_in;
         launch_ff     <= launch_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tap_ff      <= tap_in;
      last_ff     <= last_in;
      hold_max_ff <= hold_max_in;
      rsp_max_ff  <= rsp_max_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.window_max  = rsp_max_ff;
   assign rsp_ch.last_window = rsp_last_ff;

   // ------------------------------------------------------------- assertions
   // Only one running maximum may be in flight along the row at any time.
   a_single_wave : assert property (@(posedge clock) disable iff (reset)
      $onehot0({tv_out, launch_ff}))
      else $error("more than one running maximum in the cell row");

   // A wave is only started for a sample that entered the row the cycle before.
   a_launch_after_xfer : assert property (@(posedge clock) disable iff (reset)
      launch_ff |-> (state_ff == ST_RUN) && $past(req_xfer))
      else $error("running maximum started without a sample transfer");

   // A result is parked only while the output register is still occupied.
   a_hold_blocked : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HOLD) |-> rsp_valid_ff)
      else $error("result held while the output register is empty");

   // The fill count saturates at the row length.
   a_fill_range : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_MAX)
      else $error("fill count beyond the window row length");

endmodule
